### src/hrhp_pkg.sv
// Types, codes and character-class helpers for the HTTP request head parser.
`default_nettype none

package hrhp_pkg;

  localparam logic [1:0] STAT_PENDING = 2'd0;
  localparam logic [1:0] STAT_GOOD    = 2'd1;
  localparam logic [1:0] STAT_BAD     = 2'd2;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_METHOD = 3'd1;
  localparam logic [2:0] KIND_URI    = 3'd2;
  localparam logic [2:0] KIND_NAME   = 3'd3;
  localparam logic [2:0] KIND_VALUE  = 3'd4;

  localparam logic [7:0] CHAR_HT    = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_UC_H  = 8'h48;
  localparam logic [7:0] CHAR_UC_P  = 8'h50;
  localparam logic [7:0] CHAR_UC_T  = 8'h54;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CTL_LAST   = 8'h1F;
  localparam logic [7:0] VER_MAX    = 8'hFF;

  typedef enum logic [19:0] {
    ST_METHOD_START = 20'h00001,
    ST_METHOD       = 20'h00002,
    ST_URI          = 20'h00004,
    ST_VER_H        = 20'h00008,
    ST_VER_T1       = 20'h00010,
    ST_VER_T2       = 20'h00020,
    ST_VER_P        = 20'h00040,
    ST_VER_SLASH    = 20'h00080,
    ST_MAJOR_START  = 20'h00100,
    ST_MAJOR        = 20'h00200,
    ST_MINOR_START  = 20'h00400,
    ST_MINOR        = 20'h00800,
    ST_NL1          = 20'h01000,
    ST_LINE_START   = 20'h02000,
    ST_LWS          = 20'h04000,
    ST_NAME         = 20'h08000,
    ST_SPACE_BEFORE = 20'h10000,
    ST_VALUE        = 20'h20000,
    ST_NL2          = 20'h40000,
    ST_NL3          = 20'h80000
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] byte_kind;
    logic       new_header;
    logic [7:0] byte_echo;
    logic [7:0] version_major;
    logic [7:0] version_minor;
  } out_item_t;

  // Bytes with the top bit set are negative as signed chars: not CHAR, not CTL.
  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CTL_LAST) || (c == CHAR_DEL);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_tspecial(input logic [7:0] c);
    logic r;
    unique case (c)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_tspecial(c);
  endfunction

  function automatic logic [7:0] add_digit(input logic [7:0] v, input logic [7:0] c);
    logic [11:0] n;
    n = 12'(v) * 12'd10 + 12'(c - CHAR_ZERO);
    return (n > 12'(VER_MAX)) ? VER_MAX : n[7:0];
  endfunction

endpackage

`default_nettype wire

### src/http_request_head_parser_unit.sv
// Top level of the HTTP request head parser: byte register, state machine, result register.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_item  (data_byte, restart)
//   out     | output    | out_valid / out_ready| out_item (status, kind, flags, echo, versions)
//
// One byte is taken every cycle while out is not stalled; the next parse state is computed combinationally.
// A byte's result is offered on out once it has passed the input register,
// then the result register.
// Reset clears the parse state to method start, the header flag, both versions and the valids.
// A stalled out holds its result and the input register keeps one more byte before in_ready drops.
`default_nettype none

module http_request_head_parser_unit import hrhp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic         hold_valid;
  in_item_t     hold;
  logic         advance;

  parse_state_t state, state_next, eff_state;
  logic         seen_header, seen_next, eff_seen;
  logic [7:0]   major_value, major_next;
  logic [7:0]   minor_value, minor_next;
  out_item_t    result;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold <= in_item;
    end
  end

  always_comb begin
    logic [7:0] c;
    logic       ok;
    c          = hold.data_byte;
    eff_state  = hold.restart ? ST_METHOD_START : state;
    eff_seen   = hold.restart ? 1'b0 : seen_header;
    state_next = eff_state;
    seen_next  = eff_seen;
    major_next = major_value;
    minor_next = minor_value;
    ok         = 1'b1;
    result     = '0;
    result.status    = STAT_PENDING;
    result.byte_kind = KIND_NONE;
    result.byte_echo = c;

    unique case (eff_state)
      ST_METHOD_START: begin
        if (is_token(c)) begin
          state_next = ST_METHOD;
          result.byte_kind = KIND_METHOD;
        end else ok = 1'b0;
      end
      ST_METHOD: begin
        if (c == CHAR_SP) state_next = ST_URI;
        else if (is_token(c)) result.byte_kind = KIND_METHOD;
        else ok = 1'b0;
      end
      ST_URI: begin
        if (c == CHAR_SP) state_next = ST_VER_H;
        else if (is_ctl(c)) ok = 1'b0;
        else result.byte_kind = KIND_URI;
      end
      ST_VER_H: begin
        if (c == CHAR_UC_H) state_next = ST_VER_T1; else ok = 1'b0;
      end
      ST_VER_T1: begin
        if (c == CHAR_UC_T) state_next = ST_VER_T2; else ok = 1'b0;
      end
      ST_VER_T2: begin
        if (c == CHAR_UC_T) state_next = ST_VER_P; else ok = 1'b0;
      end
      ST_VER_P: begin
        if (c == CHAR_UC_P) state_next = ST_VER_SLASH; else ok = 1'b0;
      end
      ST_VER_SLASH: begin
        if (c == CHAR_SLASH) begin
          major_next = '0;
          minor_next = '0;
          state_next = ST_MAJOR_START;
        end else ok = 1'b0;
      end
      ST_MAJOR_START: begin
        if (is_digit(c)) begin
          major_next = add_digit(major_value, c);
          state_next = ST_MAJOR;
        end else ok = 1'b0;
      end
      ST_MAJOR: begin
        if (c == CHAR_DOT) state_next = ST_MINOR_START;
        else if (is_digit(c)) major_next = add_digit(major_value, c);
        else ok = 1'b0;
      end
      ST_MINOR_START: begin
        if (is_digit(c)) begin
          minor_next = add_digit(minor_value, c);
          state_next = ST_MINOR;
        end else ok = 1'b0;
      end
      ST_MINOR: begin
        if (c == CHAR_CR) state_next = ST_NL1;
        else if (is_digit(c)) minor_next = add_digit(minor_value, c);
        else ok = 1'b0;
      end
      ST_NL1: begin
        if (c == CHAR_LF) state_next = ST_LINE_START; else ok = 1'b0;
      end
      ST_LINE_START: begin
        // Folded continuation lines are only legal once a header exists.
        if (c == CHAR_CR) state_next = ST_NL3;
        else if (eff_seen && (c == CHAR_SP || c == CHAR_HT)) state_next = ST_LWS;
        else if (is_token(c)) begin
          seen_next         = 1'b1;
          state_next        = ST_NAME;
          result.byte_kind  = KIND_NAME;
          result.new_header = 1'b1;
        end else ok = 1'b0;
      end
      ST_LWS: begin
        if (c == CHAR_CR) state_next = ST_NL2;
        else if (c == CHAR_SP || c == CHAR_HT) state_next = ST_LWS;
        else if (is_ctl(c)) ok = 1'b0;
        else begin
          state_next = ST_VALUE;
          result.byte_kind = KIND_VALUE;
        end
      end
      ST_NAME: begin
        if (c == CHAR_COLON) state_next = ST_SPACE_BEFORE;
        else if (is_token(c)) result.byte_kind = KIND_NAME;
        else ok = 1'b0;
      end
      ST_SPACE_BEFORE: begin
        if (c == CHAR_SP) state_next = ST_VALUE; else ok = 1'b0;
      end
      ST_VALUE: begin
        if (c == CHAR_CR) state_next = ST_NL2;
        else if (is_ctl(c)) ok = 1'b0;
        else result.byte_kind = KIND_VALUE;
      end
      ST_NL2: begin
        if (c == CHAR_LF) state_next = ST_LINE_START; else ok = 1'b0;
      end
      ST_NL3: begin
        if (c == CHAR_LF) result.status = STAT_GOOD; else ok = 1'b0;
      end
      default: ok = 1'b0;
    endcase

    // A malformed byte changes nothing beyond what restart already did.
    if (!ok) begin
      state_next        = eff_state;
      seen_next         = eff_seen;
      major_next        = major_value;
      minor_next        = minor_value;
      result.status     = STAT_BAD;
      result.byte_kind  = KIND_NONE;
      result.new_header = 1'b0;
    end
    result.version_major = major_next;
    result.version_minor = minor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_METHOD_START;
      seen_header <= 1'b0;
      major_value <= '0;
      minor_value <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (advance) begin
        state       <= state_next;
        seen_header <= seen_next;
        major_value <= major_next;
        minor_value <= minor_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_item <= result;
    end
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("parse state lost its one-hot encoding");

  a_bad_keeps_state: assert property (@(posedge clk) disable iff (rst)
    advance && result.status == STAT_BAD |=>
      state == $past(eff_state) && seen_header == $past(eff_seen) &&
      major_value == $past(major_value) && minor_value == $past(minor_value))
    else $error("malformed beat changed the parser state");

  a_good_is_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == STAT_GOOD |->
      out_item.byte_echo == CHAR_LF && out_item.byte_kind == KIND_NONE)
    else $error("complete head reported on a beat other than the final LF");

  a_new_header_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.new_header |-> out_item.byte_kind == KIND_NAME)
    else $error("new header flagged on a beat that is not a header name byte");

  a_new_header_seen: assert property (@(posedge clk) disable iff (rst)
    advance && result.new_header |=> seen_header)
    else $error("header flag not set after a new header name");
`endif

endmodule

`default_nettype wire
